// File: rtl/core/gcic_pkg.sv
// Shared constants, codes and types of the grid cell image counters.
package gcic_pkg;

    localparam int MAX_CELLS_DEF  = 1024;
    localparam int NUM_IMAGES_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int COORD_W   = 24;
    localparam int SPAN_W    = 23;
    localparam int CELLS_W   = 6;
    localparam int MASK_W    = 16;
    localparam int CELL_W    = 10;
    localparam int IMG_W     = 4;
    localparam int OP_W      = 2;
    localparam int OUT_CNT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int QUOT_W    = 6;
    localparam int NUM_W     = SPAN_W + QUOT_W - 1;
    localparam int DIVR_W    = NUM_W - 1;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 32;

    localparam logic [CELLS_W-1:0] CELLS_MAX = 6'd32;

    localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY_IMG  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY_LIVE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GRID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_SPAN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_SPAN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 3'd6;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        logic en;
        logic up;
    } t_lane_ctrl;

endpackage

// File: rtl/core/gcic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gcic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/gcic_axis_div.sv
// Restoring divider for one axis position, two quotient bits per cycle.
module gcic_axis_div import gcic_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SPAN_W-1:0] i_span,
    output t_div_res          o_res
);

    logic              r_busy;
    logic [1:0]        r_step;
    logic              r_done;
    logic [NUM_W-1:0]  r_rem;
    logic [DIVR_W-1:0] r_div;
    logic [QUOT_W-1:0] r_quot;

    logic [NUM_W-1:0] w_d_hi;
    logic [NUM_W-1:0] w_d_lo;
    logic             w_q_hi;
    logic             w_q_lo;
    logic [NUM_W-1:0] w_rem1;
    logic [NUM_W-1:0] w_rem2;

    always_comb begin
        w_d_hi = {r_div, 1'b0};
        w_d_lo = {1'b0, r_div};
        w_q_hi = (r_rem >= w_d_hi);
        w_rem1 = w_q_hi ? (r_rem - w_d_hi) : r_rem;
        w_q_lo = (w_rem1 >= w_d_lo);
        w_rem2 = w_q_lo ? (w_rem1 - w_d_lo) : w_rem1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_div  <= {i_span, 4'd0};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_rem2;
            r_div  <= r_div >> 2;
            r_quot <= {r_quot[QUOT_W-3:0], w_q_hi, w_q_lo};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

// File: rtl/core/gcic_lane.sv
// One counter lane: saturating increment or decrement of a stored count.
module gcic_lane import gcic_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  t_lane_ctrl            i_ctrl,
    input  logic [COUNT_BITS-1:0] i_count,
    output logic [COUNT_BITS-1:0] o_count
);

    always_comb begin
        o_count = i_count;
        if (i_ctrl.en) begin
            if (i_ctrl.up) begin
                if (i_count != '1) begin
                    o_count = i_count + 1'b1;
                end
            end else if (i_count != '0) begin
                o_count = i_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/grid_cell_image_counters.sv
// Grid cell image counters: top level with sequencer, lanes and result merge.
//
// Bins tie points into a grid over a configured box and keeps one row of
// saturating counters per cell (the live count plus one counter per other
// image) in a single RAM of MAX_CELLS rows. After reset the block sweeps the
// RAM to zero, one row a cycle, with s_axis_tready low; configuration writes
// are taken throughout. An add inside the box runs from transfer to result
// through box check and numerator multiply, the two-bit-per-cycle cell
// divider and taking its quotient, RAM read and counter write-back. An add
// outside the box skips the divider. Remove and both queries go straight to
// RAM read, then write-back and result. s_axis_tready returns on the clock
// edge that loads the result. One item is in flight at a time; the result
// register lets the next item run up to write-back while a result waits on
// m_axis_tready.
module grid_cell_image_counters import gcic_pkg::*; #(
    parameter int MAX_CELLS  = MAX_CELLS_DEF,
    parameter int NUM_IMAGES = NUM_IMAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_coord, y_coord, image_mask, cell_select, image_select, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cell_index, count_value, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // out_of_box
    output logic                  m_axis_tuser
);

    localparam int LANES = ((NUM_IMAGES < MASK_W) ? NUM_IMAGES : MASK_W) - 1;
    localparam int ROW_W = (LANES + 1) * COUNT_BITS;
    localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    logic [2:0]    r_state;
    logic [AW-1:0] r_clr_addr;

    logic               r_master;
    logic [COORD_W-1:0] r_min_x;
    logic [COORD_W-1:0] r_min_y;
    logic [SPAN_W-1:0]  r_span_x;
    logic [SPAN_W-1:0]  r_span_y;
    logic [CELLS_W-1:0] r_cells_x;
    logic [CELLS_W-1:0] r_cells_y;

    logic [OP_W-1:0]    r_op;
    logic [MASK_W-1:0]  r_mask;
    logic [CELL_W-1:0]  r_sel;
    logic [IMG_W-1:0]   r_img;
    logic [COORD_W:0]   r_dx;
    logic [COORD_W:0]   r_dy;
    logic               r_oob;
    logic [CELL_W-1:0]  r_cell;
    logic               r_cell_ok;
    logic               r_upd;

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_cell;
    logic [OUT_CNT_W-1:0] r_out_count;
    logic                 r_out_oob;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_wb_done;
    logic [SPAN_W-1:0]     w_span_x;
    logic [SPAN_W-1:0]     w_span_y;
    logic [CELLS_W-1:0]    w_cx;
    logic [CELLS_W-1:0]    w_cy;
    logic                  w_in_x;
    logic                  w_in_y;
    logic [NUM_W-1:0]      w_num_x;
    logic [NUM_W-1:0]      w_num_y;
    logic                  w_div_start;
    t_div_res              w_div_x;
    t_div_res              w_div_y;
    logic [QUOT_W-1:0]     w_xp;
    logic [QUOT_W-1:0]     w_yp;
    logic [CELL_W-1:0]     w_cell_calc;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [ROW_W-1:0]      w_ram_wdata;
    logic [ROW_W-1:0]      w_rdata;
    logic [ROW_W-1:0]      w_row_nxt;
    logic [COUNT_BITS-1:0] w_cur [LANES+1];
    logic [COUNT_BITS-1:0] w_nxt [LANES+1];
    t_lane_ctrl            w_lane_ctrl [LANES+1];
    logic [COUNT_BITS-1:0] w_sel_count;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_wb_done     = (r_state == ST_WB) && w_out_free;

    always_comb begin
        w_span_x = (r_span_x == '0) ? SPAN_W'(1) : r_span_x;
        w_span_y = (r_span_y == '0) ? SPAN_W'(1) : r_span_y;
        w_cx = (r_cells_x == '0) ? CELLS_W'(1) :
               ((r_cells_x > CELLS_MAX) ? CELLS_MAX : r_cells_x);
        w_cy = (r_cells_y == '0) ? CELLS_W'(1) :
               ((r_cells_y > CELLS_MAX) ? CELLS_MAX : r_cells_y);
        w_in_x = !r_dx[COORD_W] && (r_dx[COORD_W-1:0] <= {1'b0, w_span_x});
        w_in_y = !r_dy[COORD_W] && (r_dy[COORD_W-1:0] <= {1'b0, w_span_y});
        w_num_x = NUM_W'(r_dx[SPAN_W-1:0]) * NUM_W'(w_cx);
        w_num_y = NUM_W'(r_dy[SPAN_W-1:0]) * NUM_W'(w_cy);
        w_xp = (w_div_x.quot >= w_cx) ? (w_cx - CELLS_W'(1)) : w_div_x.quot;
        w_yp = (w_div_y.quot >= w_cy) ? (w_cy - CELLS_W'(1)) : w_div_y.quot;
        w_cell_calc = CELL_W'(12'(w_yp) * 12'(w_cx) + 12'(w_xp));
    end

    assign w_div_start = (r_state == ST_PREP) && w_in_x && w_in_y;

    gcic_axis_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_x),
        .i_span  (w_span_x),
        .o_res   (w_div_x)
    );

    gcic_axis_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_y),
        .i_span  (w_span_y),
        .o_res   (w_div_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master  <= 1'b1;
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_span_x  <= SPAN_W'(16);
            r_span_y  <= SPAN_W'(16);
            r_cells_x <= CELLS_W'(1);
            r_cells_y <= CELLS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MASTER_GRID:  r_master  <= i_cfg_data[0];
                REG_BOX_MIN_X:    r_min_x   <= i_cfg_data[COORD_W-1:0];
                REG_BOX_MIN_Y:    r_min_y   <= i_cfg_data[COORD_W-1:0];
                REG_BOX_SPAN_X:   r_span_x  <= i_cfg_data[SPAN_W-1:0];
                REG_BOX_SPAN_Y:   r_span_y  <= i_cfg_data[SPAN_W-1:0];
                REG_CELLS_ACROSS: r_cells_x <= i_cfg_data[CELLS_W-1:0];
                REG_CELLS_DOWN:   r_cells_y <= i_cfg_data[CELLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= (s_axis_tuser == OP_ADD) ? ST_PREP : ST_ADDR;
                    end
                end
                ST_PREP: begin
                    r_state <= (w_in_x && w_in_y) ? ST_DIV : ST_ADDR;
                end
                ST_DIV: begin
                    if (w_div_x.done) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_mask <= s_axis_tdata[63:48];
            r_sel  <= s_axis_tdata[73:64];
            r_img  <= s_axis_tdata[77:74];
            r_cell <= s_axis_tdata[73:64];
            r_oob  <= 1'b0;
            r_dx   <= {s_axis_tdata[23], s_axis_tdata[23:0]} - {r_min_x[COORD_W-1], r_min_x};
            r_dy   <= {s_axis_tdata[47], s_axis_tdata[47:24]} - {r_min_y[COORD_W-1], r_min_y};
        end
        if (r_state == ST_PREP) begin
            r_oob  <= !(w_in_x && w_in_y);
            r_cell <= '0;
        end
        if ((r_state == ST_DIV) && w_div_x.done) begin
            r_cell <= w_cell_calc;
        end
        if (r_state == ST_ADDR) begin
            r_cell_ok <= (int'(r_cell) < MAX_CELLS);
            r_upd     <= (int'(r_cell) < MAX_CELLS) &&
                         (((r_op == OP_ADD) && !r_oob) || (r_op == OP_REMOVE));
        end
    end

    gcic_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (r_state == ST_ADDR),
        .i_raddr (AW'(r_cell)),
        .o_rdata (w_rdata)
    );

    for (genvar k = 0; k <= LANES; k++) begin : g_lane
        assign w_cur[k] = w_rdata[k*COUNT_BITS +: COUNT_BITS];
        if (k == 0) begin : g_live
            assign w_lane_ctrl[k].en = r_upd;
        end else begin : g_img
            assign w_lane_ctrl[k].en = r_upd && r_master && r_mask[k];
        end
        assign w_lane_ctrl[k].up = (r_op == OP_ADD);

        gcic_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .i_ctrl  (w_lane_ctrl[k]),
            .i_count (w_cur[k]),
            .o_count (w_nxt[k])
        );

        assign w_row_nxt[k*COUNT_BITS +: COUNT_BITS] = w_nxt[k];
    end

    always_comb begin
        w_ram_we    = (r_state == ST_CLEAR) || (w_wb_done && r_upd);
        w_ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : AW'(r_cell);
        w_ram_wdata = (r_state == ST_CLEAR) ? '0 : w_row_nxt;
    end

    always_comb begin
        w_sel_count = '0;
        case (r_op)
            OP_QUERY_IMG: begin
                if (r_cell_ok && (r_img != '0) && (int'(r_img) < NUM_IMAGES)) begin
                    for (int k = 1; k <= LANES; k++) begin
                        if (int'(r_img) == k) begin
                            w_sel_count = w_cur[k];
                        end
                    end
                end
            end
            OP_QUERY_LIVE: begin
                if (r_cell_ok) begin
                    w_sel_count = w_cur[0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_done) begin
            r_out_cell  <= r_cell;
            r_out_count <= OUT_CNT_W'(w_sel_count);
            r_out_oob   <= r_oob;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_count, r_out_cell};
    assign m_axis_tuser  = r_out_oob;

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && (r_state != ST_CLEAR)) |-> (r_cell_ok && !r_oob))
        else $error("counter row written for an unusable cell");

    a_wb_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WB) && !w_out_free) |=> (r_state == ST_WB))
        else $error("write-back left while result register full");

    a_oob_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oob) |-> ((r_out_cell == '0) && (r_out_count == '0)))
        else $error("out-of-box result carries a cell or count");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_x.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_x.done == w_div_y.done)
        else $error("axis dividers out of step");

endmodule

// File: bench/tb_grid_cell_image_counters.sv
`timescale 1ns / 1ps
// Self-checking testbench for the grid cell image counters: directed, saturation, stall and random runs.
module tb_grid_cell_image_counters;
    import gcic_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int STUCK_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int HOLD_CYCLES      = 300;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 84;
    localparam int STALL_ITEMS      = 24;
    localparam int SATURATE_ADDS    = 4;
    localparam int SATURATE_REMOVES = 10;
    localparam int MAX_REPORTS      = 200;
    localparam int OTHER_IMAGES     = NUM_IMAGES_DEF - 1;
    localparam logic [OUT_CNT_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_index;
        logic [OUT_CNT_W-1:0] count_value;
        logic                 out_of_box;
    } t_cell_result;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} t_rx_pattern;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // x_coord, y_coord, image_mask, cell_select, image_select, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // opcode
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // cell_index, count_value, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // out_of_box
    logic                  m_axis_tuser;

    logic [OUT_CNT_W-1:0] live_model [MAX_CELLS_DEF];
    logic [OUT_CNT_W-1:0] image_model [MAX_CELLS_DEF][OTHER_IMAGES];
    bit                   grid_master = 1'b1;
    longint               grid_lo_x = 0;
    longint               grid_lo_y = 0;
    int unsigned          grid_span_x = 16;
    int unsigned          grid_span_y = 16;
    int unsigned          grid_across = 1;
    int unsigned          grid_down = 1;

    t_cell_result pending_cell_results[$];
    int           mismatches = 0;
    bit           tx_gaps_on = 1'b1;
    bit           rx_stalls_on = 1'b1;
    bit           hold_request = 1'b0;
    int           burst_left = 0;
    int           hold_left = 0;
    int           rx_phase_left = 0;
    int           stuck_cycles = 0;
    t_rx_pattern  rx_pattern = RX_OPEN;

    grid_cell_image_counters i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int unsigned eff_cells(input int unsigned c);
        if (c == 0) return 1;
        if (c > CELLS_MAX) return CELLS_MAX;
        return c;
    endfunction

    function automatic bit axis_bin(input longint coord, input longint lo,
                                    input int unsigned span_reg, input int unsigned cells_reg,
                                    output int unsigned pos);
        longint span;
        longint cells;
        longint d;
        longint p;
        span = (span_reg == 0) ? 1 : span_reg;
        cells = eff_cells(cells_reg);
        d = coord - lo;
        pos = 0;
        if (d < 0 || d > span) return 1'b0;
        p = (d * cells) / span;
        if (p >= cells) p = cells - 1;
        pos = 32'(p);
        return 1'b1;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] step_count(input logic [OUT_CNT_W-1:0] v,
                                                         input bit up);
        if (up) return (v == COUNT_TOP) ? v : v + 1'b1;
        return (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic void bump_cell(input int unsigned cell_no, input logic [MASK_W-1:0] mask,
                                      input bit up);
        int k;
        if (cell_no >= MAX_CELLS_DEF) return;
        live_model[cell_no] = step_count(live_model[cell_no], up);
        if (!grid_master) return;
        for (k = 1; k < NUM_IMAGES_DEF && k < MASK_W; k++)
            if (mask[k]) image_model[cell_no][k-1] = step_count(image_model[cell_no][k-1], up);
    endfunction

    function automatic t_cell_result bin_and_count(input logic [OP_W-1:0] op,
                                                    input logic [COORD_W-1:0] x_pt,
                                                    input logic [COORD_W-1:0] y_pt,
                                                    input logic [MASK_W-1:0] mask,
                                                    input logic [CELL_W-1:0] sel,
                                                    input logic [IMG_W-1:0] img);
        t_cell_result r;
        int unsigned  xp;
        int unsigned  yp;
        int unsigned  cell_no;
        bit           in_x;
        bit           in_y;
        r.cell_index = sel;
        r.count_value = '0;
        r.out_of_box = 1'b0;
        case (op)
            OP_ADD: begin
                in_x = axis_bin(longint'($signed(x_pt)), grid_lo_x, grid_span_x, grid_across, xp);
                in_y = axis_bin(longint'($signed(y_pt)), grid_lo_y, grid_span_y, grid_down, yp);
                if (in_x && in_y) begin
                    cell_no = yp * eff_cells(grid_across) + xp;
                    r.cell_index = cell_no[CELL_W-1:0];
                    bump_cell(cell_no, mask, 1'b1);
                end else begin
                    r.cell_index = '0;
                    r.out_of_box = 1'b1;
                end
            end
            OP_REMOVE: bump_cell(sel, mask, 1'b0);
            OP_QUERY_IMG: begin
                if (sel < MAX_CELLS_DEF && img != 0 && img < NUM_IMAGES_DEF)
                    r.count_value = image_model[sel][img-1];
            end
            default: begin
                if (sel < MAX_CELLS_DEF) r.count_value = live_model[sel];
            end
        endcase
        return r;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DAT_W-1:0] data;
        data = value[CFG_DAT_W-1:0];
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_MASTER_GRID:  grid_master = data[0];
            REG_BOX_MIN_X:    grid_lo_x = longint'($signed(data));
            REG_BOX_MIN_Y:    grid_lo_y = longint'($signed(data));
            REG_BOX_SPAN_X:   grid_span_x = data[SPAN_W-1:0];
            REG_BOX_SPAN_Y:   grid_span_y = data[SPAN_W-1:0];
            REG_CELLS_ACROSS: grid_across = data[CELLS_W-1:0];
            REG_CELLS_DOWN:   grid_down = data[CELLS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input int x_pt, input int y_pt,
                             input logic [MASK_W-1:0] mask, input int sel, input int img);
        int                 gap;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [CELL_W-1:0]  ss;
        logic [IMG_W-1:0]   img_s;
        t_cell_result       want;
        xs = x_pt[COORD_W-1:0];
        ys = y_pt[COORD_W-1:0];
        ss = sel[CELL_W-1:0];
        img_s = img[IMG_W-1:0];
        if (tx_gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, img_s, ss, mask, ys, xs};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        want = bin_and_count(op, xs, ys, mask, ss, img_s);
        pending_cell_results = {pending_cell_results, want};
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_cell_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic longint pick_offset(input longint span);
        case ($urandom_range(0, 11))
            0: return 0;
            1: return span;
            2: return span + 1;
            3: return -1;
            4: return -longint'($urandom_range(1, 5000));
            5: return span + longint'($urandom_range(1, 5000));
            default: return longint'($urandom_range(0, span));
        endcase
    endfunction

    task automatic send_random_item();
        logic [OP_W-1:0]   op;
        logic [MASK_W-1:0] mask;
        int                x_pt;
        int                y_pt;
        int                sel;
        int                img;
        int                n_cells;
        op = OP_W'($urandom);
        mask = MASK_W'($urandom);
        x_pt = $urandom;
        y_pt = $urandom;
        sel = $urandom;
        img = $urandom;
        if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: op = OP_ADD;
                5, 6:          op = OP_REMOVE;
                7, 8:          op = OP_QUERY_IMG;
                default:       op = OP_QUERY_LIVE;
            endcase
            x_pt = int'(grid_lo_x + pick_offset((grid_span_x == 0) ? 1 : grid_span_x));
            y_pt = int'(grid_lo_y + pick_offset((grid_span_y == 0) ? 1 : grid_span_y));
            n_cells = eff_cells(grid_across) * eff_cells(grid_down);
            if ($urandom_range(0, 7) != 0) sel = $urandom_range(0, n_cells - 1);
            img = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, OTHER_IMAGES);
        end
        send_item(op, x_pt, y_pt, mask, sel, img);
    endtask

    function automatic int random_span();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(1, 64);
            2: return $urandom_range(1, 5000);
            3: return $urandom;
            4: return 8388607;
            default: return $urandom_range(64, 70000);
        endcase
    endfunction

    function automatic int random_cells();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(1, 4);
            2: return $urandom_range(1, 32);
            3: return $urandom_range(33, 63);
            4: return 32;
            default: return $urandom;
        endcase
    endfunction

    function automatic int random_lo();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return $urandom_range(0, 4000) - 2000;
            2: return $urandom;
            3: return -8388608;
            default: return 8388607;
        endcase
    endfunction

    task automatic load_random_config();
        cfg_write(REG_MASTER_GRID, $urandom_range(0, 3));
        cfg_write(REG_BOX_MIN_X, random_lo());
        cfg_write(REG_BOX_MIN_Y, random_lo());
        cfg_write(REG_BOX_SPAN_X, random_span());
        cfg_write(REG_BOX_SPAN_Y, random_span());
        cfg_write(REG_CELLS_ACROSS, random_cells());
        cfg_write(REG_CELLS_DOWN, random_cells());
    endtask

    task automatic test_default_box();
        send_item(OP_ADD, 0, 0, 16'hFFFF, 0, 0);
        send_item(OP_ADD, 16, 16, 16'h0001, 0, 0);
        send_item(OP_ADD, 17, 5, 16'hFFFF, 0, 0);
        wait_drained();
    endtask

    task automatic test_counter_saturation();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (SATURATE_ADDS) send_item(OP_ADD, 5, 5, 16'hFFFF, 0, 0);
        send_item(OP_QUERY_LIVE, 0, 0, 16'h0000, 0, 0);
        repeat (SATURATE_REMOVES) send_item(OP_REMOVE, 0, 0, 16'hFFFF, 0, 0);
        send_item(OP_QUERY_LIVE, 0, 0, 16'h0000, 0, 0);
        send_item(OP_QUERY_IMG, 0, 0, 16'h0000, 0, 9);
        wait_drained();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_grid_cells();
        cfg_write(REG_BOX_MIN_X, -100);
        cfg_write(REG_BOX_MIN_Y, 50);
        cfg_write(REG_BOX_SPAN_X, 400);
        cfg_write(REG_BOX_SPAN_Y, 300);
        cfg_write(REG_CELLS_ACROSS, 4);
        cfg_write(REG_CELLS_DOWN, 3);
        send_item(OP_ADD, -100, 50, 16'h8001, 0, 0);
        send_item(OP_ADD, 300, 350, 16'hFFFF, 0, 0);
        send_item(OP_ADD, -8388608, 8388607, 16'hFFFF, 0, 0);
        send_item(OP_REMOVE, 0, 0, 16'hAAAA, 11, 0);
        send_item(OP_REMOVE, 0, 0, 16'hFFFF, 20, 0);
        send_item(OP_QUERY_LIVE, 0, 0, 16'h0000, 11, 0);
        send_item(OP_QUERY_IMG, 0, 0, 16'h0000, 11, 4);
        send_item(OP_QUERY_IMG, 0, 0, 16'h0000, 11, 0);
        send_item(OP_QUERY_IMG, 0, 0, 16'h0000, 1023, 15);
        wait_drained();
        cfg_write(REG_MASTER_GRID, 0);
        send_item(OP_ADD, 0, 200, 16'hFFFF, 0, 0);
        send_item(OP_QUERY_IMG, 0, 0, 16'h0000, 5, 1);
        wait_drained();
        cfg_write(REG_MASTER_GRID, 1);
    endtask

    task automatic test_register_extremes();
        cfg_write(REG_BOX_MIN_X, 0);
        cfg_write(REG_BOX_MIN_Y, 0);
        cfg_write(REG_BOX_SPAN_X, 0);
        cfg_write(REG_BOX_SPAN_Y, 0);
        cfg_write(REG_CELLS_ACROSS, 0);
        cfg_write(REG_CELLS_DOWN, 0);
        send_item(OP_ADD, 1, 1, 16'h0F0F, 0, 0);
        send_item(OP_ADD, 2, 0, 16'h0F0F, 0, 0);
        wait_drained();
        cfg_write(REG_BOX_MIN_X, -8388608);
        cfg_write(REG_BOX_MIN_Y, -8388608);
        cfg_write(REG_BOX_SPAN_X, 24'hFFFFFF);
        cfg_write(REG_BOX_SPAN_Y, 8388607);
        cfg_write(REG_CELLS_ACROSS, 63);
        cfg_write(REG_CELLS_DOWN, 40);
        send_item(OP_ADD, -1, -1, 16'hFFFF, 0, 0);
        send_item(OP_ADD, 8388607, -8388608, 16'hFFFF, 0, 0);
        wait_drained();
        cfg_write(REG_BOX_MIN_X, 8388607);
        send_item(OP_ADD, 8388607, -8388608, 16'h1234, 0, 0);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (STALL_ITEMS) send_random_item();
        wait_drained();
    endtask

    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < PHASES; phase++) begin
            load_random_config();
            repeat (ITEMS_PER_PHASE) send_random_item();
            wait_drained();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_stalls_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_phase_left == 0) begin
                rx_pattern = t_rx_pattern'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(8, 64);
            end
            rx_phase_left--;
            case (rx_pattern)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= rx_phase_left[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_cell_result seen;
        t_cell_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.cell_index  = m_axis_tdata[CELL_W-1:0];
            seen.count_value = m_axis_tdata[CELL_W +: OUT_CNT_W];
            seen.out_of_box  = m_axis_tuser;
            if (pending_cell_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $error("unexpected result transfer: cell_index %0d", seen.cell_index);
                mismatches++;
            end else begin
                want = pending_cell_results.pop_front();
                if (seen.cell_index !== want.cell_index) begin
                    if (mismatches < MAX_REPORTS)
                        $error("cell_index: expected %0d, actual %0d",
                               want.cell_index, seen.cell_index);
                    mismatches++;
                end
                if (seen.count_value !== want.count_value) begin
                    if (mismatches < MAX_REPORTS)
                        $error("count_value: expected %0d, actual %0d",
                               want.count_value, seen.count_value);
                    mismatches++;
                end
                if (seen.out_of_box !== want.out_of_box) begin
                    if (mismatches < MAX_REPORTS)
                        $error("out_of_box: expected %0d, actual %0d",
                               want.out_of_box, seen.out_of_box);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < MAX_CELLS_DEF; c++) begin
            live_model[c] = '0;
            for (int k = 0; k < OTHER_IMAGES; k++) image_model[c][k] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_box();
        test_counter_saturation();
        test_grid_cells();
        test_register_extremes();
        test_output_backpressure();
        test_random_phases();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_cell_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gcic_pkg.sv
rtl/core/gcic_ram.sv
rtl/core/gcic_axis_div.sv
rtl/core/gcic_lane.sv
rtl/core/grid_cell_image_counters.sv
bench/tb_grid_cell_image_counters.sv
